[design/rqa_pkg.sv]
// ----------------------------------------------------------------------------
// rqa_pkg: shared types and constants of the retransmit queue
// Holds queue sizing, register indexes, request codes and the payload
// structures of the command and result channels.
// ----------------------------------------------------------------------------
package rqa_pkg;

   // Queue sizing.
   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int LEVEL_W     = 6;

   // Field widths.
   localparam int CODE_W  = 8;
   localparam int COUNT_W = 4;
   localparam int WAIT_W  = 16;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ACK_PACKET_CODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_SEND_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REQ_SEND_COUNT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_WAIT_TICKS = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [CODE_W-1:0]  ACK_PACKET_CODE_RST  = 8'd0;
   localparam logic [COUNT_W-1:0] ACK_SEND_COUNT_RST   = 4'd1;
   localparam logic [COUNT_W-1:0] REQ_SEND_COUNT_RST   = 4'd3;
   localparam logic [WAIT_W-1:0]  RETRY_WAIT_TICKS_RST = 16'd50;

   // Request codes.
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_ACK     = 2'd1;
   localparam logic [1:0] REQ_TICK    = 2'd2;

   // Command payload.
   typedef struct packed {
      logic [1:0]        req_type;
      logic [CODE_W-1:0] packet;
      logic              tx_idle;
   } req_item_type;

   // Result payload.
   typedef struct packed {
      logic               send_valid;
      logic [CODE_W-1:0]  send_packet;
      logic               enqueue_dropped;
      logic [LEVEL_W-1:0] queue_level;
      logic [COUNT_W-1:0] sends_left;
   } rsp_item_type;

   // One queue entry: remaining transmissions and packet code.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [CODE_W-1:0]  code;
   } entry_type;

endpackage

[design/retransmit_queue_with_ack.sv]
// A result strobes on rsp_valid once start has passed the input register and then the result register.
// Throughput: one command per cycle; busy is always low, and the result
// register is written every cycle, so the receiver never stalls the block.
// The head entry is prefetched from the queue memory each cycle with a
// write bypass, so a pop never waits on the memory read port.
// Synchronous reset empties the queue, expires the timer and loads defaults.
// ----------------------------------------------------------------------------
// retransmit_queue_with_ack: transmit queue with retries and ack cancel
// Queues packet codes with a transmission count, resends the current packet
// on idle timer ticks and drops it early when its acknowledgement arrives.
// ----------------------------------------------------------------------------
module retransmit_queue_with_ack
   import rqa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [CODE_W-1:0]  ack_code_ff;
   logic [COUNT_W-1:0] ack_count_ff;
   logic [COUNT_W-1:0] req_count_ff;
   logic [WAIT_W-1:0]  retry_wait_ff;

   // Input register.
   logic         in_valid_ff;
   req_item_type in_item_ff;

   // Queue and transmit state.
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [CODE_W-1:0]  cur_code_ff, cur_code_in;
   logic [COUNT_W-1:0] cur_left_ff, cur_left_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;

   // Queue memory and prefetched head entry.
   entry_type          mem_store [QUEUE_DEPTH];
   entry_type          head_entry_ff;
   logic               wr_en;
   entry_type          wr_data;

   // Result register.
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic               is_full;
   logic [COUNT_W-1:0] enq_count;

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_code_ff   <= ACK_PACKET_CODE_RST;
         ack_count_ff  <= ACK_SEND_COUNT_RST;
         req_count_ff  <= REQ_SEND_COUNT_RST;
         retry_wait_ff <= RETRY_WAIT_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACK_PACKET_CODE:  ack_code_ff   <= csr_wdata[CODE_W-1:0];
            CSR_ACK_SEND_COUNT:   ack_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_REQ_SEND_COUNT:   req_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_RETRY_WAIT_TICKS: retry_wait_ff <= csr_wdata[WAIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Command capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
      in_item_ff <= req_item;
   end

   assign is_full   = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign enq_count = (in_item_ff.packet == ack_code_ff) ? ack_count_ff : req_count_ff;

   // Next state and result for the registered command.
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      cur_code_in = cur_code_ff;
      cur_left_in = cur_left_ff;
      wait_in     = wait_ff;
      wr_en       = 1'b0;
      wr_data.count = enq_count;
      wr_data.code  = in_item_ff.packet;
      rsp_item_in.send_valid      = 1'b0;
      rsp_item_in.send_packet     = '0;
      rsp_item_in.enqueue_dropped = 1'b0;

      if (in_valid_ff) begin
         unique case (in_item_ff.req_type)
            REQ_ENQUEUE: begin
               if (is_full) begin
                  rsp_item_in.enqueue_dropped = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
            REQ_ACK: begin
               if (in_item_ff.packet == cur_code_ff) begin
                  cur_left_in = '0;
               end
            end
            REQ_TICK: begin
               if (wait_ff != '0) begin
                  wait_in = wait_ff - 1'b1;
               end else if (in_item_ff.tx_idle) begin
                  if (cur_left_ff == '0) begin
                     // Nothing left to resend: pop the next packet if any.
                     if (fill_ff != '0) begin
                        head_in     = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                                      '0 : head_ff + 1'b1;
                        fill_in     = fill_ff - 1'b1;
                        cur_code_in = head_entry_ff.code;
                        cur_left_in = (head_entry_ff.count != '0) ?
                                      head_entry_ff.count - 1'b1 : '0;
                        rsp_item_in.send_valid  = 1'b1;
                        rsp_item_in.send_packet = head_entry_ff.code;
                     end
                  end else begin
                     cur_left_in = cur_left_ff - 1'b1;
                     rsp_item_in.send_valid  = 1'b1;
                     rsp_item_in.send_packet = cur_code_ff;
                  end
                  wait_in = retry_wait_ff;
               end
            end
            default: ;
         endcase
      end

      rsp_item_in.queue_level = LEVEL_W'(fill_in);
      rsp_item_in.sends_left  = cur_left_in;
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         cur_code_ff  <= '0;
         cur_left_ff  <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         cur_code_ff  <= cur_code_in;
         cur_left_ff  <= cur_left_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= in_valid_ff;
      end
      rsp_item_ff <= rsp_item_in;
   end

   // Queue memory: one write port, one registered read of the next head.
   // A write to the address being read is forwarded so the prefetch is current.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_store[tail_ff] <= wr_data;
      end
      if (wr_en && (tail_ff == head_in)) begin
         head_entry_ff <= wr_data;
      end else begin
         head_entry_ff <= mem_store[head_in];
      end
   end

endmodule
